// ===== rtl/core/positional_array_store_top_defines.svh =====
// Assertion macros used by the positional array store controller.
`ifndef POSITIONAL_ARRAY_STORE_TOP_DEFINES_SVH
`define POSITIONAL_ARRAY_STORE_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define PAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define PAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pas_pkg.sv =====
// Package: widths, codes and shared types of the positional array store.
package pas_pkg;

  localparam int DEPTH        = 16;
  localparam int ELEMENT_BITS = 32;

  localparam int ACT_W   = 3;
  localparam int POS_W   = 8;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef logic [ELEMENT_BITS-1:0] elem_t;
  typedef logic [WORD_W-1:0]       word_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [ACT_W-1:0]        act_t;
  typedef logic [STAT_W-1:0]       stat_t;
  typedef logic [2:0]              cell_op_t;

  // Request actions
  localparam act_t ACT_GET         = 3'd0;
  localparam act_t ACT_SET         = 3'd1;
  localparam act_t ACT_APPEND      = 3'd2;
  localparam act_t ACT_INSERT      = 3'd3;
  localparam act_t ACT_INSERT_FAST = 3'd4;
  localparam act_t ACT_REMOVE      = 3'd5;
  localparam act_t ACT_REMOVE_FAST = 3'd6;
  localparam act_t ACT_CLEAR       = 3'd7;

  // Result status
  localparam stat_t ST_OK    = 2'd0;
  localparam stat_t ST_RANGE = 2'd1;
  localparam stat_t ST_FULL  = 2'd2;

  // Per-beat cell operations
  localparam cell_op_t OP_NONE      = 3'd0;
  localparam cell_op_t OP_WRITE     = 3'd1;
  localparam cell_op_t OP_INS_SHIFT = 3'd2;
  localparam cell_op_t OP_INS_FAST  = 3'd3;
  localparam cell_op_t OP_REM_SHIFT = 3'd4;
  localparam cell_op_t OP_REM_FAST  = 3'd5;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t op;
    idx_t     tgt;
    cnt_t     len;
    elem_t    value;
  } cmd_t;

endpackage

// ===== rtl/core/pas_if.sv =====
// Request and response channel interfaces of the positional array store.
interface pas_req_if;
  logic                          valid;
  logic                          ready;
  logic [pas_pkg::ACT_W-1:0]     action;
  logic [pas_pkg::POS_W-1:0]     position;
  logic [pas_pkg::WORD_W-1:0]    item_value;

  modport source (output valid, action, position, item_value, input ready);
  modport sink   (input valid, action, position, item_value, output ready);
endinterface

interface pas_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pas_pkg::STAT_W-1:0]    status;
  logic [pas_pkg::WORD_W-1:0]    read_value;
  logic [pas_pkg::COUNT_W-1:0]   element_count;

  modport source (output valid, status, read_value, element_count, input ready);
  modport sink   (input valid, status, read_value, element_count, output ready);
endinterface

// ===== rtl/core/pas_cell.sv =====
// One storage cell of the element row: holds one element, shifts with neighbors.
module pas_cell (
  input  logic           clk,
  input  pas_pkg::idx_t  index,
  input  pas_pkg::cmd_t  cmd,
  input  pas_pkg::elem_t left,
  input  pas_pkg::elem_t right,
  input  pas_pkg::elem_t pick_in,
  input  pas_pkg::elem_t pick_all,
  input  pas_pkg::idx_t  pick_idx,
  output pas_pkg::elem_t pick_out,
  output pas_pkg::elem_t data
);

  pas_pkg::elem_t data_next;
  pas_pkg::cnt_t  k;
  logic           at_tgt;

  assign k      = pas_pkg::cnt_t'(index);
  assign at_tgt = (index == cmd.tgt);

  // OR chain: only the selected cell contributes
  assign pick_out = pick_in | ((index == pick_idx) ? data : '0);

  always_comb begin
    data_next = data;
    case (cmd.op)
      pas_pkg::OP_WRITE: begin
        if (at_tgt) data_next = cmd.value;
      end
      pas_pkg::OP_INS_SHIFT: begin
        if (at_tgt) data_next = cmd.value;
        else if (index > cmd.tgt && k <= cmd.len) data_next = left;
      end
      pas_pkg::OP_INS_FAST: begin
        if (at_tgt) data_next = cmd.value;
        else if (k == cmd.len) data_next = pick_all;
      end
      pas_pkg::OP_REM_SHIFT: begin
        if (index >= cmd.tgt && (k + pas_pkg::cnt_t'(1)) < cmd.len) data_next = right;
      end
      pas_pkg::OP_REM_FAST: begin
        // source is the last element, which sits at or past this cell on the chain
        if (at_tgt) data_next = pick_all;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== rtl/core/pas_ctrl.sv =====
// Request decoder, length register and result register of the array store.
`include "positional_array_store_top_defines.svh"

module pas_ctrl (
  input  logic            clk,
  input  logic            rst,
  pas_req_if.sink         req,
  pas_rsp_if.source       rsp,
  input  pas_pkg::elem_t  pick,
  output pas_pkg::idx_t   pick_idx,
  output pas_pkg::cmd_t   cmd
);

  pas_pkg::cnt_t     len;
  pas_pkg::cnt_t     len_next;
  pas_pkg::cnt_t     len_m1;
  pas_pkg::cell_op_t op;
  pas_pkg::idx_t     tgt;
  pas_pkg::stat_t    st;
  pas_pkg::word_t    rd;
  logic              accept;
  logic              in_range;
  logic              full;
  logic              out_valid;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign len_m1   = len - pas_pkg::cnt_t'(1);
  assign in_range = pas_pkg::CMP_W'(req.position) < pas_pkg::CMP_W'(len);
  assign full     = (len == pas_pkg::cnt_t'(pas_pkg::DEPTH));
  assign pick_idx = (req.action == pas_pkg::ACT_REMOVE_FAST) ?
                    len_m1[pas_pkg::IDX_W-1:0] : req.position[pas_pkg::IDX_W-1:0];

  always_comb begin
    op       = pas_pkg::OP_NONE;
    tgt      = req.position[pas_pkg::IDX_W-1:0];
    st       = pas_pkg::ST_OK;
    rd       = '0;
    len_next = len;
    unique case (req.action) inside
      pas_pkg::ACT_GET: begin
        if (in_range) rd = pas_pkg::word_t'(pick);
        else st = pas_pkg::ST_RANGE;
      end
      pas_pkg::ACT_REMOVE, pas_pkg::ACT_REMOVE_FAST: begin
        if (in_range) begin
          op       = (req.action == pas_pkg::ACT_REMOVE) ?
                     pas_pkg::OP_REM_SHIFT : pas_pkg::OP_REM_FAST;
          len_next = len_m1;
        end else begin
          st = pas_pkg::ST_RANGE;
        end
      end
      pas_pkg::ACT_CLEAR: begin
        len_next = '0;
      end
      default: begin
        // set, append, insert, insert_fast: all may grow the list
        if (in_range && req.action == pas_pkg::ACT_SET) begin
          op = pas_pkg::OP_WRITE;
        end else if (full) begin
          st = pas_pkg::ST_FULL;
        end else if (in_range && req.action == pas_pkg::ACT_INSERT) begin
          op       = pas_pkg::OP_INS_SHIFT;
          len_next = len + pas_pkg::cnt_t'(1);
        end else if (in_range && req.action == pas_pkg::ACT_INSERT_FAST) begin
          op       = pas_pkg::OP_INS_FAST;
          len_next = len + pas_pkg::cnt_t'(1);
        end else begin
          // append at the end
          op       = pas_pkg::OP_WRITE;
          tgt      = len[pas_pkg::IDX_W-1:0];
          len_next = len + pas_pkg::cnt_t'(1);
        end
      end
    endcase
  end

  assign cmd.op    = accept ? op : pas_pkg::OP_NONE;
  assign cmd.tgt   = tgt;
  assign cmd.len   = len;
  assign cmd.value = pas_pkg::elem_t'(req.item_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        len       <= len_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status        <= st;
      rsp.read_value    <= rd;
      rsp.element_count <= pas_pkg::COUNT_W'(len_next);
    end
  end

  assign rsp.valid = out_valid;

  `PAS_ASSERT_NOW(a_len_bound, 1'b1, len <= pas_pkg::cnt_t'(pas_pkg::DEPTH), "length above depth")
  `PAS_ASSERT_NEXT(a_clear_empties, accept && req.action == pas_pkg::ACT_CLEAR, len == '0, "clear left elements")
  `PAS_ASSERT_NOW(a_count_tracks, out_valid, rsp.element_count == pas_pkg::COUNT_W'(len), "count differs from length")
  `PAS_ASSERT_NOW(a_full_at_depth, out_valid && rsp.status == pas_pkg::ST_FULL, len == pas_pkg::cnt_t'(pas_pkg::DEPTH), "full status below depth")
  `PAS_ASSERT_NOW(a_read_only_ok, out_valid && rsp.status != pas_pkg::ST_OK, rsp.read_value == '0, "read value on failed request")

endmodule

// ===== rtl/core/positional_array_store_top.sv =====
// Top level of the positional array store: controller plus a row of element cells.
//
// Ordered list of up to DEPTH elements with a current length. Each request beat
// on req carries action, position and item_value; each one produces exactly one
// response beat on rsp with status (ok, out of range, full), read_value (the
// element for a successful get, else zero) and element_count after the request.
// Elements live in a row of cells. Every cell updates in the accept cycle:
// shifting inserts and removes move the whole tail one place through the
// neighbor links, fast inserts and removes copy one element over a shared
// OR chain that also carries the get result.
// Latency: the response is registered and valid the cycle after the request beat.
// Throughput: one request per cycle unless a response waits on a low rsp.ready; the cell update sets the pace.
// Stall: the result register holds while rsp.ready is low, and req.ready follows
// rsp.ready while a response waits, so no request is taken that has nowhere
// to land.
// Reset (rst, synchronous): length becomes zero and no response is pending.
// Cell contents are not cleared; only positions below the length are visible.
module positional_array_store_top (
  input  logic      clk,
  input  logic      rst,
  pas_req_if.sink   req,
  pas_rsp_if.source rsp
);

  pas_pkg::cmd_t  cmd;
  pas_pkg::idx_t  pick_idx;
  pas_pkg::elem_t data [pas_pkg::DEPTH];
  pas_pkg::elem_t pick_bus [pas_pkg::DEPTH+1];

  assign pick_bus[0] = '0;

  pas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .pick     (pick_bus[pas_pkg::DEPTH]),
    .pick_idx (pick_idx),
    .cmd      (cmd)
  );

  // Cell row: each cell sees its left and right neighbor for tail shifts,
  // and the end of the OR chain for single-element copies
  for (genvar k = 0; k < pas_pkg::DEPTH; k++) begin : g_cell
    pas_pkg::elem_t left;
    pas_pkg::elem_t right;

    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = data[k-1];
    end

    if (k == pas_pkg::DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = data[k+1];
    end

    pas_cell u_cell (
      .clk      (clk),
      .index    (pas_pkg::idx_t'(k)),
      .cmd      (cmd),
      .left     (left),
      .right    (right),
      .pick_in  (pick_bus[k]),
      .pick_all (pick_bus[pas_pkg::DEPTH]),
      .pick_idx (pick_idx),
      .pick_out (pick_bus[k+1]),
      .data     (data[k])
    );
  end

endmodule

// ===== sim/pas_checker.sv =====
// Checker: tracks the list contents, predicts each response beat and compares it.
module pas_checker
  import pas_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pas_req_if   req,
  pas_rsp_if   rsp,
  output int   mismatches,
  output int   pending,
  output int   list_len
);

  typedef struct packed {
    stat_t               status;
    word_t               read_value;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  elem_t    cells [DEPTH];
  int       len;
  int       errs;
  outcome_t awaited [$];

  function automatic stat_t push_tail(elem_t v);
    if (len >= DEPTH) return ST_FULL;
    cells[len] = v;
    len++;
    return ST_OK;
  endfunction

  function automatic outcome_t apply_request(act_t act, logic [POS_W-1:0] pos, word_t value);
    outcome_t o;
    elem_t    v;
    int       p;
    v = value[ELEMENT_BITS-1:0];
    p = int'(pos);
    o.status = ST_OK;
    o.read_value = '0;
    case (act)
      ACT_GET: begin
        if (p < len) o.read_value = cells[p];
        else o.status = ST_RANGE;
      end
      ACT_SET: begin
        if (p < len) cells[p] = v;
        else o.status = push_tail(v);
      end
      ACT_APPEND: o.status = push_tail(v);
      ACT_INSERT: begin
        if (p >= len) o.status = push_tail(v);
        else if (len >= DEPTH) o.status = ST_FULL;
        else begin
          for (int i = len; i > p; i--) cells[i] = cells[i-1];
          cells[p] = v;
          len++;
        end
      end
      ACT_INSERT_FAST: begin
        if (p >= len) o.status = push_tail(v);
        else if (len >= DEPTH) o.status = ST_FULL;
        else begin
          // displaced element moves to the tail
          cells[len] = cells[p];
          cells[p] = v;
          len++;
        end
      end
      ACT_REMOVE: begin
        if (p < len) begin
          for (int i = p; i + 1 < len; i++) cells[i] = cells[i+1];
          len--;
        end else o.status = ST_RANGE;
      end
      ACT_REMOVE_FAST: begin
        if (p < len) begin
          cells[p] = cells[len-1];
          len--;
        end else o.status = ST_RANGE;
      end
      ACT_CLEAR: begin
        len = 0;
        foreach (cells[i]) cells[i] = '0;
      end
      default: ;
    endcase
    o.count = COUNT_W'(len);
    return o;
  endfunction

  task automatic flag(input bit orphan, input outcome_t want, input outcome_t got);
    errs++;
    if (errs <= 10) begin
      if (orphan)
        $display("unexpected response beat: status %0d read_value %h count %0d",
                 got.status, got.read_value, got.count);
      else
        $display("response mismatch (exp/got): status %0d/%0d read_value %h/%h count %0d/%0d",
                 want.status, got.status, want.read_value, got.read_value,
                 want.count, got.count);
    end
  endtask

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      awaited.delete();
      len = 0;
    end else begin
      // response first: it can only belong to an earlier request beat
      if (rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.read_value, rsp.element_count};
        if (awaited.size() == 0) begin
          flag(1'b1, '0, got);
        end else begin
          want = awaited.pop_front();
          if (got !== want) flag(1'b0, want, got);
        end
      end
      if (req.valid && req.ready)
        awaited.push_back(apply_request(req.action, req.position, req.item_value));
    end
    mismatches <= errs;
    pending    <= awaited.size();
    list_len   <= len;
  end

endmodule

// ===== sim/tb_positional_array_store_top.sv =====
// Testbench top: clock, reset, request stimulus, response stalls and verdict.
module tb_positional_array_store_top;
  import pas_pkg::*;

  // Cycles without any beat on either channel before the run is declared hung.
  // Worst legit quiet stretch is the long receiver hold-off plus a gap.
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES  = 80;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_RHYTHM} stall_mode_t;

  logic clk = 1'b0;
  logic rst;

  pas_req_if req ();
  pas_rsp_if rsp ();

  int fail_count;
  int pending;
  int list_len;
  int hold_asked = 0;   // bumped by the sender to request one long receiver hold-off
  int idle_cycles = 0;

  positional_array_store_top uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  pas_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .mismatches (fail_count),
    .pending    (pending),
    .list_len   (list_len)
  );

  always #6 clk = ~clk;

  // Watchdog: any beat on either side resets the count.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: switches between stall patterns at random intervals, and does
  // one long hold-off when the sender asks for it, counted here.
  initial begin : receiver
    stall_mode_t mode;
    int          mode_left;
    int          hold_left;
    int          holds_done;
    int          tick;
    mode       = STALL_NONE;
    mode_left  = 0;
    hold_left  = 0;
    holds_done = 0;
    tick       = 0;
    rsp.ready  = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_asked != holds_done) begin
        holds_done = hold_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  rsp.ready <= 1'b1;
          STALL_COIN:  rsp.ready <= 1'($urandom_range(0, 1));
          STALL_HEAVY: rsp.ready <= ($urandom_range(0, 3) == 0);
          default:     rsp.ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  // One request beat: hold valid and payload until the block takes it.
  // Returns in the step of the accepting edge, so a following call keeps
  // valid high with no extra assignment.
  task automatic send(input act_t act, input logic [POS_W-1:0] pos, input word_t value);
    req.valid      <= 1'b1;
    req.action     <= act;
    req.position   <= pos;
    req.item_value <= value;
    do @(posedge clk); while (!req.ready);
  endtask

  // Sender gap; payload wiggles while valid is low.
  task automatic pause(input int cycles);
    if (cycles > 0) begin
      req.valid      <= 1'b0;
      req.action     <= act_t'($urandom);
      req.position   <= POS_W'($urandom);
      req.item_value <= $urandom;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Sender stops until every outstanding response has come back.
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Action mix: grow_pct steers toward lengthening ops so the list reaches
  // full; the rest is mostly reads/overwrites and removes, with occasional clears and random actions.
  function automatic act_t pick_action(input int grow_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return ACT_CLEAR;
    if (r < 7) return act_t'($urandom);
    if (r < 7 + grow_pct) return act_t'($urandom_range(ACT_SET, ACT_INSERT_FAST));
    if (r < 27 + grow_pct) return ($urandom_range(0, 1) != 0) ? ACT_GET : ACT_SET;
    return ($urandom_range(0, 1) != 0) ? ACT_REMOVE : ACT_REMOVE_FAST;
  endfunction

  // Mostly positions inside or just past the list, some at the far end of the
  // field and some fully random so every position bit toggles.
  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return POS_W'($urandom_range(0, list_len));
    if (r < 8) return '1;
    return POS_W'($urandom);
  endfunction

  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic random_phase(input int count);
    int burst_left;
    int grow_pct;
    burst_left = 0;
    grow_pct   = 50;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        case ($urandom_range(0, 2))
          0:       grow_pct = 30;
          1:       grow_pct = 50;
          default: grow_pct = 70;
        endcase
        // a third of the bursts follow straight on: no idle at all
        pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
      end
      burst_left--;
      // long receiver hold-off while the sender keeps offering beats
      if (n == count / 3) hold_asked <= hold_asked + 1;
      // mid-run the sender waits for every response before going on
      if (n == (2 * count) / 3) drain();
      send(pick_action(grow_pct), pick_position(), pick_value());
    end
  endtask

  initial begin : stimulus
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.action     = ACT_GET;
    req.position   = '0;
    req.item_value = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list corner cases
    send(ACT_GET,         8'd0,   32'h0);          // get past end
    send(ACT_REMOVE,      8'd0,   32'h0);          // remove past end
    send(ACT_REMOVE_FAST, 8'hFF,  32'h0);          // remove_fast past end
    // basic growth, extreme values
    send(ACT_APPEND,      8'd0,   32'hFFFF_FFFF);
    send(ACT_APPEND,      8'hFF,  32'h0);
    send(ACT_SET,         8'hFF,  32'hA5A5_0001);  // set past end appends
    send(ACT_SET,         8'd0,   32'h1234_5678);  // overwrite in place
    send(ACT_INSERT,      8'd0,   32'h0000_0011);  // shifting insert at head
    send(ACT_INSERT,      8'hFF,  32'h0000_0022);  // insert past end appends
    send(ACT_INSERT_FAST, 8'd1,   32'h0000_0033);  // old element goes to tail
    send(ACT_GET,         8'd3,   32'h0);
    send(ACT_GET,         8'hFF,  32'h0);
    send(ACT_REMOVE,      8'd1,   32'h0);          // shifting remove
    send(ACT_REMOVE_FAST, 8'd4,   32'h0);          // remove_fast of last element
    send(ACT_REMOVE_FAST, 8'd0,   32'h0);          // tail fills the hole
    // top up to capacity, then every growth path must report full
    repeat (DEPTH - 3) send(ACT_APPEND, 8'd0, $urandom);
    send(ACT_APPEND,      8'd0,   32'hDEAD_BEEF);
    send(ACT_SET,         8'd200, 32'hDEAD_BEEF);
    send(ACT_INSERT,      8'd0,   32'hDEAD_BEEF);
    send(ACT_INSERT_FAST, 8'd5,   32'hDEAD_BEEF);
    send(ACT_SET,         8'd15,  32'h8000_0001);  // overwrite last slot when full
    send(ACT_GET,         8'd15,  32'h0);
    send(ACT_GET,         8'd16,  32'h0);
    send(ACT_CLEAR,       8'd9,   32'hFFFF_FFFF);
    send(ACT_GET,         8'd0,   32'h0);
    drain();

    random_phase(RANDOM_ITEMS);

    // wind down: nothing left in flight, then a wait for stray beats
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== positional_array_store_top.f =====
+incdir+rtl/core
rtl/core/pas_pkg.sv
rtl/core/pas_if.sv
rtl/core/pas_cell.sv
rtl/core/pas_ctrl.sv
rtl/core/positional_array_store_top.sv
sim/pas_checker.sv
sim/tb_positional_array_store_top.sv
